// ----- rtl/sdc_pkg.sv -----
// ----------------------------------------------------------------------------
// sdc_pkg
// shared constants, state type and calendar helpers for the serial date
// converter
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

  // direction codes carried on in_tuser
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam int DEFAULT_MAX_YEAR_OFFSET = 8099;

  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] SEC_LAST     = 17'd86399;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;
  localparam logic [16:0] DAYS_LEAP    = 17'd366;
  localparam logic [16:0] DAYS_COMMON  = 17'd365;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;

  // year counters: 1900 sits at 0 mod 4, 0 mod 100, 300 mod 400
  localparam logic [8:0]  MOD400_START = 9'd300;
  localparam logic [6:0]  MOD100_LAST  = 7'd99;
  localparam logic [8:0]  MOD400_LAST  = 9'd399;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_YEAR  = 8'b0000_0010,
    S_MON   = 8'b0000_0100,
    S_HR    = 8'b0000_1000,
    S_MIN   = 8'b0001_0000,
    S_CARRY = 8'b0010_0000,
    S_DAY   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // month length, months past december count no days
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/serial_date_converter.sv -----
// ----------------------------------------------------------------------------
// serial_date_converter
// spreadsheet serial date <-> calendar date and time, 1900 leap quirk kept
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: date, time, serial; tuser: cmd
//  out_    | out | out_tvalid/tready  | tdata: serial, date, time;
//          |     |                    | tuser: range error
//
//  one item at a time through a single add/subtract unit and a small sequencer
//  encode: walks the years and the months, then adds the time carry and the day
//  (the year walk is one year per cycle)
//  decode: walks the years, then the months, hours and minutes of what is left
//  rst_n is synchronous; it clears the sequencer and the output valid flag
//  a new item is taken while a finished result still waits in the output
//  register; a stalled output holds the sequencer in its last state
// ----------------------------------------------------------------------------
`default_nettype none

module serial_date_converter
  import sdc_pkg::*;
#(
  parameter int MAX_YEAR_OFFSET = DEFAULT_MAX_YEAR_OFFSET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in: valid / ready handshake
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // low to high: in_year_offset[13] in_month[4] in_day[5] in_hour[5]
  // in_minute[6] in_second[6] in_serial_days[22] in_serial_seconds[17] pad[2]
  input  wire logic [79:0] in_tdata,
  // cmd[1]
  input  wire logic [0:0]  in_tuser,
  // out: valid / ready handshake
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // low to high: out_serial_days[22] out_serial_seconds[17] out_year_offset[13]
  // out_month[4] out_day[5] out_hour[5] out_minute[6] out_second[6] pad[2]
  output logic [79:0]      out_tdata,
  // out_range_error[1]
  output logic [0:0]       out_tuser
);

  localparam logic [12:0] MaxYear = 13'(MAX_YEAR_OFFSET);

  // input field unpacking
  logic [12:0] in_year_offset;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic [21:0] in_serial_days;
  logic [16:0] in_serial_seconds;

  assign in_year_offset    = in_tdata[12:0];
  assign in_month          = in_tdata[16:13];
  assign in_day            = in_tdata[21:17];
  assign in_hour           = in_tdata[26:22];
  assign in_minute         = in_tdata[32:27];
  assign in_second         = in_tdata[38:33];
  assign in_serial_days    = in_tdata[60:39];
  assign in_serial_seconds = in_tdata[77:61];

  state_t      state_r, state_nxt;
  logic        cmd_r, cmd_nxt;
  logic [21:0] acc_r, acc_nxt;        // day count, built up or worn down
  logic [16:0] sec_r, sec_nxt;        // seconds of the day
  logic [12:0] yoff_r, yoff_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [12:0] tgt_year_r, tgt_year_nxt;
  logic [3:0]  tgt_mon_r, tgt_mon_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic        carry_r, carry_nxt;
  logic        err_r, err_nxt;
  logic [1:0]  m4_r, m4_nxt;
  logic [6:0]  m100_r, m100_nxt;
  logic [8:0]  m400_r, m400_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [79:0] out_tdata_r, out_tdata_nxt;
  logic [0:0]  out_tuser_r, out_tuser_nxt;

  // shared add/subtract unit
  logic [21:0] alu_a;
  logic [16:0] alu_b;
  logic        alu_sub;
  logic [22:0] alu_full;
  logic [21:0] alu_res;
  logic        alu_ge;
  logic        alu_gt;

  assign alu_full = alu_sub ? ({1'b0, alu_a} - {6'd0, alu_b})
                            : ({1'b0, alu_a} + {6'd0, alu_b});
  assign alu_res  = alu_full[21:0];
  assign alu_ge   = ~alu_full[22];
  assign alu_gt   = alu_ge && (alu_res != 22'd0);

  // calendar of the current year
  logic        leap;
  logic [16:0] ylen;
  logic [4:0]  mlen;

  assign leap = (yoff_r == 13'd0) || (m400_r == 9'd0) ||
                ((m4_r == 2'd0) && (m100_r != 7'd0));
  assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen = month_len(mon_r, leap);

  // encode time sum and decode saturation at load
  logic [16:0] raw_secs;
  logic [16:0] sat_secs;

  assign raw_secs = 17'(in_hour) * SEC_PER_HOUR + 17'(in_minute) * SEC_PER_MIN
                  + 17'(in_second);
  assign sat_secs = (in_serial_seconds >= SEC_PER_DAY) ? SEC_LAST : in_serial_seconds;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    alu_a   = acc_r;
    alu_b   = ylen;
    alu_sub = 1'b0;
    unique case (state_r)
      S_YEAR: begin
        alu_b   = ylen;
        alu_sub = (cmd_r == CMD_DECODE);
      end
      S_MON: begin
        alu_b   = 17'(mlen);
        alu_sub = (cmd_r == CMD_DECODE);
      end
      S_HR: begin
        alu_a   = 22'(sec_r);
        alu_b   = SEC_PER_HOUR;
        alu_sub = 1'b1;
      end
      S_MIN: begin
        alu_a   = 22'(sec_r);
        alu_b   = SEC_PER_MIN;
        alu_sub = 1'b1;
      end
      S_CARRY: begin
        alu_a   = 22'(sec_r);
        alu_b   = SEC_PER_DAY;
        alu_sub = 1'b1;
      end
      S_DAY: begin
        alu_b   = 17'(day_r) + 17'(carry_r);
      end
      default: begin
        alu_a   = acc_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    acc_nxt       = acc_r;
    sec_nxt       = sec_r;
    yoff_nxt      = yoff_r;
    mon_nxt       = mon_r;
    tgt_year_nxt  = tgt_year_r;
    tgt_mon_nxt   = tgt_mon_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    carry_nxt     = carry_r;
    err_nxt       = err_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_tuser[0];
          yoff_nxt     = 13'd0;
          mon_nxt      = 4'd0;
          tgt_year_nxt = in_year_offset;
          tgt_mon_nxt  = in_month;
          day_nxt      = in_day;
          hour_nxt     = 5'd0;
          min_nxt      = 6'd0;
          carry_nxt    = 1'b0;
          err_nxt      = 1'b0;
          m4_nxt       = 2'd0;
          m100_nxt     = 7'd0;
          m400_nxt     = MOD400_START;
          if (in_tuser[0] == CMD_DECODE) begin
            acc_nxt = in_serial_days;
            sec_nxt = sat_secs;
          end else begin
            acc_nxt = 22'd0;
            sec_nxt = raw_secs;
          end
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        priority if ((cmd_r == CMD_ENCODE && yoff_r < tgt_year_r) ||
                     (cmd_r == CMD_DECODE && yoff_r < MaxYear && alu_gt)) begin
          acc_nxt  = alu_res;
          yoff_nxt = yoff_r + 13'd1;
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == MOD100_LAST) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == MOD400_LAST) ? 9'd0 : m400_r + 9'd1;
        end else begin
          // past the last supported year: clamp to its last day
          if (cmd_r == CMD_DECODE && alu_gt) begin
            err_nxt = 1'b1;
            acc_nxt = 22'(ylen);
          end
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        priority if ((cmd_r == CMD_ENCODE && mon_r < tgt_mon_r) ||
                     (cmd_r == CMD_DECODE && mon_r < LAST_MONTH && alu_gt)) begin
          acc_nxt = alu_res;
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = (cmd_r == CMD_DECODE) ? S_HR : S_CARRY;
        end
      end
      S_HR: begin
        if (alu_ge) begin
          sec_nxt  = alu_res[16:0];
          hour_nxt = hour_r + 5'd1;
        end else begin
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (alu_ge) begin
          sec_nxt = alu_res[16:0];
          min_nxt = min_r + 6'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CARRY: begin
        // time sum of a full day or more rolls into the day count
        if (alu_ge) begin
          sec_nxt   = alu_res[16:0];
          carry_nxt = 1'b1;
        end
        state_nxt = S_DAY;
      end
      S_DAY: begin
        acc_nxt   = alu_res;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_DECODE) begin
            out_tdata_nxt = {2'b00, sec_r[5:0], min_r, hour_r, acc_r[4:0], mon_r,
                             yoff_r, 17'd0, 22'd0};
            out_tuser_nxt = err_r;
          end else begin
            out_tdata_nxt = {2'b00, 6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 13'd0, sec_r, acc_r};
            out_tuser_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    acc_r       <= acc_nxt;
    sec_r       <= sec_nxt;
    yoff_r      <= yoff_nxt;
    mon_r       <= mon_nxt;
    tgt_year_r  <= tgt_year_nxt;
    tgt_mon_r   <= tgt_mon_nxt;
    day_r       <= day_nxt;
    hour_r      <= hour_nxt;
    min_r       <= min_nxt;
    carry_r     <= carry_nxt;
    err_r       <= err_nxt;
    m4_r        <= m4_nxt;
    m100_r      <= m100_nxt;
    m400_r      <= m400_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/sdc_checker.sv -----
// ----------------------------------------------------------------------------
// sdc_checker
// port-level checks for the serial date converter
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready after accept");

  // range error only comes with a decode, whose serial fields are zero
  a_err_decode_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[38:0] == 39'd0)
    else $error("range error with serial fields set");

  // decoded calendar and time fields stay in range
  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:52] <= 4'd11 && out_tdata[65:61] <= 5'd23 &&
                   out_tdata[71:66] <= 6'd59 && out_tdata[77:72] <= 6'd59)
    else $error("decoded field out of range");

endmodule

bind serial_date_converter sdc_checker u_sdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- tb/sv/serial_date_converter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_date_converter_checker
// watches both channels of the serial date converter, predicts the result of
// every accepted item and compares it field by field in order
// ----------------------------------------------------------------------------
module serial_date_converter_checker
  import sdc_pkg::*;
#(
  parameter int MAX_YEAR_OFFSET = DEFAULT_MAX_YEAR_OFFSET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic [0:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [79:0] out_tdata,
  input  wire logic [0:0]  out_tuser,
  output int unsigned      fail_count,
  output int unsigned      pending,
  output int unsigned      results_seen,
  output int unsigned      range_flags_seen
);

  // last member sits in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [16:0] serial_seconds;
    logic [21:0] serial_days;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [12:0] year_offset;
  } date_request_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [12:0] year_offset;
    logic [16:0] serial_seconds;
    logic [21:0] serial_days;
  } date_result_t;

  typedef struct {
    date_result_t fields;
    logic         range_error;
  } date_expect_t;

  date_expect_t expected_dates[$];

  // 1900 counts as leap, the spreadsheet quirk
  function automatic bit leap_year(int unsigned off);
    int unsigned y;
    y = 1900 + off;
    return (off == 0) || (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned year_days(int unsigned off);
    return leap_year(off) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(int unsigned mon, int unsigned off);
    case (mon)
      0, 2, 4, 6, 7, 9, 11: return 31;
      3, 5, 8, 10:          return 30;
      1:                    return leap_year(off) ? 29 : 28;
      default:              return 0;
    endcase
  endfunction

  function automatic date_expect_t convert_date(logic cmd, date_request_t req);
    date_expect_t res;
    int unsigned  days;
    int unsigned  secs;
    int unsigned  yoff;
    int unsigned  mon;
    int unsigned  hr;
    int unsigned  mi;
    int unsigned  se;
    res.fields      = '0;
    res.range_error = 1'b0;
    days = 0;
    yoff = 0;
    mon  = 0;
    if (cmd == CMD_ENCODE) begin
      for (int unsigned i = 0; i < req.year_offset; i++) days += year_days(i);
      for (int unsigned i = 0; i < req.month; i++) days += month_days(i, req.year_offset);
      days += req.day;
      hr   = req.hour;
      mi   = req.minute;
      se   = req.second;
      secs = hr * 3600 + mi * 60 + se;
      // out-of-range time fields carry at most one day
      if (secs >= 86400) begin
        secs -= 86400;
        days++;
      end
      res.fields.serial_days    = days[21:0];
      res.fields.serial_seconds = secs[16:0];
    end else begin
      days = req.serial_days;
      secs = req.serial_seconds;
      while (yoff < MAX_YEAR_OFFSET && days > year_days(yoff)) begin
        days -= year_days(yoff);
        yoff++;
      end
      // past the last year: pin to its last day
      if (days > year_days(yoff)) begin
        res.range_error = 1'b1;
        days = year_days(yoff);
      end
      while (mon < 11 && days > month_days(mon, yoff)) begin
        days -= month_days(mon, yoff);
        mon++;
      end
      if (secs >= 86400) secs = 86399;
      hr = secs / 3600;
      mi = (secs % 3600) / 60;
      se = secs % 60;
      res.fields.year_offset = yoff[12:0];
      res.fields.month       = mon[3:0];
      res.fields.day         = days[4:0];
      res.fields.hour        = hr[4:0];
      res.fields.minute      = mi[5:0];
      res.fields.second      = se[5:0];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    date_expect_t want;
    date_result_t got;
    if (!rst_n) begin
      expected_dates.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_dates.push_back(convert_date(in_tuser[0], in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_dates.size() == 0) begin
          $error("result with no item waiting: tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("out_serial_days", want.fields.serial_days, got.serial_days);
          check_field("out_serial_seconds", want.fields.serial_seconds, got.serial_seconds);
          check_field("out_year_offset", want.fields.year_offset, got.year_offset);
          check_field("out_month", want.fields.month, got.month);
          check_field("out_day", want.fields.day, got.day);
          check_field("out_hour", want.fields.hour, got.hour);
          check_field("out_minute", want.fields.minute, got.minute);
          check_field("out_second", want.fields.second, got.second);
          check_field("out_range_error", want.range_error, out_tuser[0]);
          results_seen++;
          range_flags_seen += out_tuser[0];
        end
      end
    end
    pending = expected_dates.size();
  end

endmodule

// ----- tb/sv/serial_date_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_date_converter_tb
// directed calendar corners, then random encode and decode items under four
// idle and stall mixes; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module serial_date_converter_tb
  import sdc_pkg::*;
();

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 80;
  localparam int PHASES       = 4;
  // a full decode walks about 8100 years, one per cycle; this leaves
  // several times that with room for a stalled receiver
  localparam int WATCHDOG_LIMIT = 40000;
  // the block holds nothing once its last result has left
  localparam int DRAIN_CYCLES = 32;

  // per-phase percentages: none, sender gaps, receiver stalls, both
  localparam int unsigned SENDER_IDLE_MIX[PHASES]    = '{0, 50, 0, 9};
  localparam int unsigned RECEIVER_STALL_MIX[PHASES] = '{0, 0, 50, 9};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned range_flags_seen;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned encodes_sent       = 0;
  int unsigned decodes_sent       = 0;
  int unsigned quiet_cycles       = 0;

  always #HALF_PERIOD clk = ~clk;

  serial_date_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  serial_date_converter_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .range_flags_seen (range_flags_seen)
  );

  // receiver: a fresh coin each cycle, weighted by the current phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
  end

  // watchdog: count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("serial_date_converter test failed");
    $finish;
  end

  // offer one item, with random sender gaps first; valid stays high from one
  // item to the next when no gap is drawn
  task automatic push_conversion(input logic cmd, input int unsigned yoff,
                                 input int unsigned mon, input int unsigned day,
                                 input int unsigned hr, input int unsigned mi,
                                 input int unsigned se, input int unsigned sdays,
                                 input int unsigned ssecs);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    // low to high: year, month, day, hour, minute, second, serial days,
    // serial seconds, two pad bits
    in_tdata  <= {2'b00, ssecs[16:0], sdays[21:0], se[5:0], mi[5:0], hr[4:0],
                  day[4:0], mon[3:0], yoff[12:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_ENCODE) encodes_sent++;
    else decodes_sent++;
  endtask

  // mostly short walks (small years, small serials) so the run stays fast;
  // one in ten reaches across the whole range, including past the last year
  task automatic push_random_conversion();
    logic        cmd;
    int unsigned yoff;
    int unsigned mon;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    int unsigned sdays;
    int unsigned ssecs;
    cmd   = $urandom_range(1, 0) ? CMD_DECODE : CMD_ENCODE;
    yoff  = ($urandom_range(9, 0) == 0) ? $urandom_range(8191, 0) : $urandom_range(255, 0);
    mon   = ($urandom_range(7, 0) == 0) ? $urandom_range(15, 12) : $urandom_range(11, 0);
    hr    = ($urandom_range(7, 0) == 0) ? $urandom_range(31, 24) : $urandom_range(23, 0);
    mi    = ($urandom_range(7, 0) == 0) ? $urandom_range(63, 60) : $urandom_range(59, 0);
    se    = ($urandom_range(7, 0) == 0) ? $urandom_range(63, 60) : $urandom_range(59, 0);
    sdays = ($urandom_range(9, 0) == 0) ? $urandom_range(4194303, 0)
                                        : $urandom_range(100000, 0);
    ssecs = ($urandom_range(7, 0) == 0) ? $urandom_range(131071, 86400)
                                        : $urandom_range(86399, 0);
    push_conversion(cmd, yoff, mon, $urandom_range(31, 0), hr, mi, se, sdays, ssecs);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, no idling on either side
    // encode: serial zero, day one, the phantom 1900-02-29 and the day after
    push_conversion(CMD_ENCODE, 0, 0, 0, 0, 0, 0, 0, 0);
    push_conversion(CMD_ENCODE, 0, 0, 1, 0, 0, 1, 0, 0);
    push_conversion(CMD_ENCODE, 0, 1, 29, 12, 0, 0, 0, 0);
    push_conversion(CMD_ENCODE, 0, 2, 1, 0, 0, 0, 0, 0);
    // 2000 is leap, 2100 is not
    push_conversion(CMD_ENCODE, 100, 1, 29, 6, 30, 15, 0, 0);
    push_conversion(CMD_ENCODE, 200, 2, 0, 0, 0, 0, 0, 0);
    // last supported day and time
    push_conversion(CMD_ENCODE, 8099, 11, 31, 23, 59, 59, 0, 0);
    // every field at all ones, unused serial fields too; time carries a day
    push_conversion(CMD_ENCODE, 8191, 15, 31, 31, 63, 63, 4194303, 131071);
    // month past december counts the whole year
    push_conversion(CMD_ENCODE, 5, 12, 10, 0, 0, 0, 0, 0);
    // april 31 goes through unchecked
    push_conversion(CMD_ENCODE, 3, 3, 31, 0, 0, 0, 0, 0);
    // exactly one day of seconds
    push_conversion(CMD_ENCODE, 1, 0, 1, 24, 0, 0, 0, 0);

    // decode: serial zero, first days, leap quirk, year boundaries
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 0, 0);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 1, 1);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 60, 86399);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 61, 3600);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 366, 60);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 367, 0);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 36526, 43210);
    // last supported serial, then one past it
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 2958465, 86399);
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 2958466, 0);
    // all ones on every field, seconds saturate
    push_conversion(CMD_DECODE, 8191, 15, 31, 31, 63, 63, 4194303, 131071);
    // seconds just past the day
    push_conversion(CMD_DECODE, 0, 0, 0, 0, 0, 0, 1000, 86400);

    // random items, a quarter under each idle mix
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct    = SENDER_IDLE_MIX[ph];
      receiver_stall_pct = RECEIVER_STALL_MIX[ph];
      repeat (RANDOM_ITEMS / PHASES) push_random_conversion();
    end
    in_tvalid <= 1'b0;

    // let the checker log the last item before looking at what is left
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d encode and %0d decode items, %0d results checked, %0d range flags",
             encodes_sent, decodes_sent, results_seen, range_flags_seen);
    $display("idle mixes: none, sender gaps, receiver stalls, light on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("serial_date_converter test passed");
    end else begin
      $display("serial_date_converter test failed");
    end
    $finish;
  end

endmodule
